### rtl/rtnh_pkg.sv
// ----------------------------------------------------------------------------
// rtnh_pkg
// shared types, constants and the product schedule of the nearest-hit block
// ----------------------------------------------------------------------------
package rtnh_pkg;

  localparam int AW = 104;
  localparam int NUM_STEPS = 36;
  localparam logic [15:0] INDEX_CAP = 16'hFFFF;
  localparam logic [30:0] T_ALL_ONES = 31'h7FFF_FFFF;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X = 3'd3;
  localparam logic [2:0] REG_DIR_Y = 3'd4;
  localparam logic [2:0] REG_DIR_Z = 3'd5;
  localparam logic [2:0] REG_DET_THR = 3'd6;
  localparam logic [2:0] REG_MIN_DIST = 3'd7;

  localparam logic [2:0] SRC_D = 3'd0;
  localparam logic [2:0] SRC_E1 = 3'd1;
  localparam logic [2:0] SRC_E2 = 3'd2;
  localparam logic [2:0] SRC_TV = 3'd3;
  localparam logic [2:0] SRC_PL = 3'd4;
  localparam logic [2:0] SRC_PH = 3'd5;
  localparam logic [2:0] SRC_QL = 3'd6;
  localparam logic [2:0] SRC_QH = 3'd7;

  localparam logic [2:0] DST_NONE = 3'd0;
  localparam logic [2:0] DST_P = 3'd1;
  localparam logic [2:0] DST_Q = 3'd2;
  localparam logic [2:0] DST_DET = 3'd3;
  localparam logic [2:0] DST_UN = 3'd4;
  localparam logic [2:0] DST_VN = 3'd5;
  localparam logic [2:0] DST_TN = 3'd6;

  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][31:0] dir;
    logic [62:0]      thr;
    logic [30:0]      min_dist;
  } cfg_t;

  typedef struct packed {
    logic [2:0][32:0] e1;
    logic [2:0][32:0] e2;
    logic [2:0][32:0] tv;
    logic             last;
  } tri_t;

  typedef struct packed {
    logic             found;
    logic [30:0]      distance;
    logic [15:0]      index;
    logic [2:0][31:0] coord;
  } res_t;

  typedef struct packed {
    logic [2:0] a_src;
    logic [1:0] a_idx;
    logic [2:0] b_src;
    logic [1:0] b_idx;
    logic       neg;
    logic       shift;
    logic       clr;
    logic       last;
    logic [2:0] dst;
    logic [1:0] dst_idx;
  } ucode_t;

  function automatic ucode_t mk(input logic [2:0] as, input logic [1:0] ai,
                                input logic [2:0] bs, input logic [1:0] bi,
                                input logic neg, input logic clr, input logic last,
                                input logic [2:0] dst, input logic [1:0] di);
    ucode_t u;
    u.a_src = as;
    u.a_idx = ai;
    u.b_src = bs;
    u.b_idx = bi;
    u.neg = neg;
    u.shift = (bs == SRC_PH) || (bs == SRC_QH);
    u.clr = clr;
    u.last = last;
    u.dst = dst;
    u.dst_idx = di;
    return u;
  endfunction

  // p = d x e2, q = tv x e1, then det, un, vn, tn as split dot products
  function automatic ucode_t ucode(input logic [5:0] step);
    ucode_t u;
    case (step)
      6'd0:  u = mk(SRC_D, 2'd1, SRC_E2, 2'd2, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd1:  u = mk(SRC_D, 2'd2, SRC_E2, 2'd1, 1'b1, 1'b0, 1'b1, DST_P, 2'd0);
      6'd2:  u = mk(SRC_D, 2'd2, SRC_E2, 2'd0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd3:  u = mk(SRC_D, 2'd0, SRC_E2, 2'd2, 1'b1, 1'b0, 1'b1, DST_P, 2'd1);
      6'd4:  u = mk(SRC_D, 2'd0, SRC_E2, 2'd1, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd5:  u = mk(SRC_D, 2'd1, SRC_E2, 2'd0, 1'b1, 1'b0, 1'b1, DST_P, 2'd2);
      6'd6:  u = mk(SRC_TV, 2'd1, SRC_E1, 2'd2, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd7:  u = mk(SRC_TV, 2'd2, SRC_E1, 2'd1, 1'b1, 1'b0, 1'b1, DST_Q, 2'd0);
      6'd8:  u = mk(SRC_TV, 2'd2, SRC_E1, 2'd0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd9:  u = mk(SRC_TV, 2'd0, SRC_E1, 2'd2, 1'b1, 1'b0, 1'b1, DST_Q, 2'd1);
      6'd10: u = mk(SRC_TV, 2'd0, SRC_E1, 2'd1, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd11: u = mk(SRC_TV, 2'd1, SRC_E1, 2'd0, 1'b1, 1'b0, 1'b1, DST_Q, 2'd2);
      6'd12: u = mk(SRC_E1, 2'd0, SRC_PL, 2'd0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd13: u = mk(SRC_E1, 2'd0, SRC_PH, 2'd0, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd14: u = mk(SRC_E1, 2'd1, SRC_PL, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd15: u = mk(SRC_E1, 2'd1, SRC_PH, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd16: u = mk(SRC_E1, 2'd2, SRC_PL, 2'd2, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd17: u = mk(SRC_E1, 2'd2, SRC_PH, 2'd2, 1'b0, 1'b0, 1'b1, DST_DET, 2'd0);
      6'd18: u = mk(SRC_TV, 2'd0, SRC_PL, 2'd0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd19: u = mk(SRC_TV, 2'd0, SRC_PH, 2'd0, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd20: u = mk(SRC_TV, 2'd1, SRC_PL, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd21: u = mk(SRC_TV, 2'd1, SRC_PH, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd22: u = mk(SRC_TV, 2'd2, SRC_PL, 2'd2, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd23: u = mk(SRC_TV, 2'd2, SRC_PH, 2'd2, 1'b0, 1'b0, 1'b1, DST_UN, 2'd0);
      6'd24: u = mk(SRC_D, 2'd0, SRC_QL, 2'd0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd25: u = mk(SRC_D, 2'd0, SRC_QH, 2'd0, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd26: u = mk(SRC_D, 2'd1, SRC_QL, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd27: u = mk(SRC_D, 2'd1, SRC_QH, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd28: u = mk(SRC_D, 2'd2, SRC_QL, 2'd2, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd29: u = mk(SRC_D, 2'd2, SRC_QH, 2'd2, 1'b0, 1'b0, 1'b1, DST_VN, 2'd0);
      6'd30: u = mk(SRC_E2, 2'd0, SRC_QL, 2'd0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      6'd31: u = mk(SRC_E2, 2'd0, SRC_QH, 2'd0, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd32: u = mk(SRC_E2, 2'd1, SRC_QL, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd33: u = mk(SRC_E2, 2'd1, SRC_QH, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd34: u = mk(SRC_E2, 2'd2, SRC_QL, 2'd2, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      6'd35: u = mk(SRC_E2, 2'd2, SRC_QH, 2'd2, 1'b0, 1'b0, 1'b1, DST_TN, 2'd0);
      default: u = mk(SRC_D, 2'd0, SRC_D, 2'd0, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
    endcase
    return u;
  endfunction

endpackage

### rtl/ray_triangle_nearest_hit_top.sv
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit_top
// nearest ray/triangle hit over a triangle stream, configuration registers
// ----------------------------------------------------------------------------
// Each triangle runs through the engine once: 36 passes of one shared 34x34
// multiplier form the cross and dot products, bound tests follow, and a
// restoring divider produces t one bit per cycle unless the triangle is
// rejected by the bound tests or t saturates. The last triangle of a mesh then
// forms the hit point (same multiplier) and hands the result word to the output
// register; the next mesh waits until that word has moved into that register.
// A two-word queue at the input lets triangles be pushed while the engine is busy.
module ray_triangle_nearest_hit_top import rtnh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] a_x,
  input  logic [31:0] a_y,
  input  logic [31:0] a_z,
  input  logic [31:0] b_x,
  input  logic [31:0] b_y,
  input  logic [31:0] b_z,
  input  logic [31:0] c_x,
  input  logic [31:0] c_y,
  input  logic [31:0] c_z,
  input  logic        last_triangle,
  output logic        empty,
  input  logic        pop,
  output logic        found,
  output logic [30:0] hit_distance,
  output logic [15:0] hit_triangle,
  output logic [31:0] hit_x,
  output logic [31:0] hit_y,
  output logic [31:0] hit_z,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [62:0] wr_data
);

  cfg_t cfg;
  logic item_valid;
  tri_t item;
  logic item_take;
  logic res_we;
  res_t res;
  res_t out_word;
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.org <= '0;
      cfg.dir <= {32'h0001_0000, 32'h0, 32'h0};
      cfg.thr <= 63'd281474977;
      cfg.min_dist <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_ORIGIN_X: begin
          cfg.org[0] <= wr_data[31:0];
        end
        REG_ORIGIN_Y: begin
          cfg.org[1] <= wr_data[31:0];
        end
        REG_ORIGIN_Z: begin
          cfg.org[2] <= wr_data[31:0];
        end
        REG_DIR_X: begin
          cfg.dir[0] <= wr_data[31:0];
        end
        REG_DIR_Y: begin
          cfg.dir[1] <= wr_data[31:0];
        end
        REG_DIR_Z: begin
          cfg.dir[2] <= wr_data[31:0];
        end
        REG_DET_THR: begin
          cfg.thr <= wr_data;
        end
        REG_MIN_DIST: begin
          cfg.min_dist <= wr_data[30:0];
        end
        default: begin
        end
      endcase
    end
  end

  rtnh_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .a_x           (a_x),
    .a_y           (a_y),
    .a_z           (a_z),
    .b_x           (b_x),
    .b_y           (b_y),
    .b_z           (b_z),
    .c_x           (c_x),
    .c_y           (c_y),
    .c_z           (c_z),
    .last_triangle (last_triangle),
    .cfg           (cfg),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take)
  );

  rtnh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_free   (!out_valid),
    .res_we     (res_we),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (res_we) begin
      out_word <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_we) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign empty = !out_valid;
  assign found = out_word.found;
  assign hit_distance = out_word.distance;
  assign hit_triangle = out_word.index;
  assign hit_x = out_word.coord[0];
  assign hit_y = out_word.coord[1];
  assign hit_z = out_word.coord[2];

endmodule

### rtl/rtnh_front.sv
// ----------------------------------------------------------------------------
// rtnh_front
// takes triangles, forms edge and origin offset vectors, two-word queue
// ----------------------------------------------------------------------------
module rtnh_front import rtnh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] a_x,
  input  logic [31:0] a_y,
  input  logic [31:0] a_z,
  input  logic [31:0] b_x,
  input  logic [31:0] b_y,
  input  logic [31:0] b_z,
  input  logic [31:0] c_x,
  input  logic [31:0] c_y,
  input  logic [31:0] c_z,
  input  logic        last_triangle,
  input  cfg_t        cfg,
  output logic        item_valid,
  output tri_t        item,
  input  logic        item_take
);

  tri_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  tri_t       word;
  logic [2:0][31:0] va;
  logic [2:0][31:0] vb;
  logic [2:0][31:0] vc;
  logic       wr;
  logic       rd;

  assign va = {a_z, a_y, a_x};
  assign vb = {b_z, b_y, b_x};
  assign vc = {c_z, c_y, c_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      word.e1[i] = {vb[i][31], vb[i]} - {va[i][31], va[i]};
      word.e2[i] = {vc[i][31], vc[i]} - {va[i][31], va[i]};
      word.tv[i] = {cfg.org[i][31], cfg.org[i]} - {va[i][31], va[i]};
    end
    word.last = last_triangle;
  end

  assign full = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item = slot[rd_ptr];
  assign wr = push && !full;
  assign rd = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      slot[wr_ptr] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

### rtl/rtnh_back.sv
// ----------------------------------------------------------------------------
// rtnh_back
// product sequencer, bound tests, restoring divider and nearest-hit tracking
// ----------------------------------------------------------------------------
module rtnh_back import rtnh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic item_valid,
  input  tri_t item,
  output logic item_take,
  input  logic res_free,
  output logic res_we,
  output res_t res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_DIV = 3'd5;
  localparam logic [2:0] S_UPD = 3'd6;
  localparam logic [2:0] S_COORD = 3'd7;

  logic [2:0]  state;
  logic        out_pend;
  tri_t        cur;
  logic [5:0]  step;
  ucode_t      uc;
  ucode_t      ctl_r;
  logic        ctl_v;
  logic signed [33:0] opa;
  logic signed [33:0] opb;
  logic signed [67:0] prod_r;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] addend;
  logic signed [AW-1:0] acc_next;
  logic [2:0][66:0] p;
  logic [2:0][66:0] q;
  logic [AW-1:0] det;
  logic [AW-1:0] un;
  logic [AW-1:0] vn;
  logic [AW-1:0] tn;
  logic [AW:0]   uv_sum;
  logic          hit_ok;
  logic          chk_ok;
  logic          big;
  logic [119:0]  rem;
  logic [133:0]  dsh;
  logic [4:0]    dbit;
  logic [30:0]   t;
  logic [30:0]   best_t;
  logic [15:0]   best_index;
  logic          any_hit;
  logic [15:0]   triangle_count;
  logic          new_best;
  logic [1:0]    cidx;
  logic [1:0]    cprev;
  logic [2:0][31:0] coord;
  logic signed [52:0] csum;
  logic [31:0]   csat;
  logic [31:0]   cdir;
  logic [31:0]   corg;

  function automatic logic signed [33:0] pick(input logic [2:0] src, input logic [1:0] idx,
                                              input tri_t tr, input cfg_t c,
                                              input logic [2:0][66:0] pv,
                                              input logic [2:0][66:0] qv);
    logic [1:0] k;
    logic signed [33:0] r;
    k = (idx == 2'd3) ? 2'd0 : idx;
    case (src)
      SRC_D:  r = {{2{c.dir[k][31]}}, c.dir[k]};
      SRC_E1: r = {tr.e1[k][32], tr.e1[k]};
      SRC_E2: r = {tr.e2[k][32], tr.e2[k]};
      SRC_TV: r = {tr.tv[k][32], tr.tv[k]};
      SRC_PL: r = {1'b0, pv[k][32:0]};
      SRC_PH: r = pv[k][66:33];
      SRC_QL: r = {1'b0, qv[k][32:0]};
      SRC_QH: r = qv[k][66:33];
      default: r = '0;
    endcase
    return r;
  endfunction

  assign uc = ucode(step);
  assign item_take = (state == S_IDLE) && !out_pend && item_valid;

  always_comb begin
    case (cidx)
      2'd0: begin
        cdir = cfg.dir[0];
      end
      2'd1: begin
        cdir = cfg.dir[1];
      end
      default: begin
        cdir = cfg.dir[2];
      end
    endcase
    case (cprev)
      2'd0: begin
        corg = cfg.org[0];
      end
      2'd1: begin
        corg = cfg.org[1];
      end
      default: begin
        corg = cfg.org[2];
      end
    endcase
  end

  always_comb begin
    if (state == S_COORD) begin
      opa = {3'b000, best_t};
      opb = {{2{cdir[31]}}, cdir};
    end else begin
      opa = pick(uc.a_src, uc.a_idx, cur, cfg, p, q);
      opb = pick(uc.b_src, uc.b_idx, cur, cfg, p, q);
    end
  end

  always_comb begin
    if (ctl_r.shift) begin
      addend = {{(AW - 68){prod_r[67]}}, prod_r} <<< 33;
    end else begin
      addend = {{(AW - 68){prod_r[67]}}, prod_r};
    end
    acc_next = (ctl_r.clr ? '0 : acc) + (ctl_r.neg ? -addend : addend);
  end

  // hit tests on the sign-corrected sums
  assign uv_sum = {1'b0, un} + {1'b0, vn};
  assign chk_ok = (det > {{(AW - 63){1'b0}}, cfg.thr}) && !un[AW-1] && !vn[AW-1]
                  && (uv_sum <= {1'b0, det}) && !tn[AW-1] && (tn != '0);
  assign big = {15'b0, tn, 16'b0} >= {det, 31'b0};
  assign new_best = hit_ok && (t > cfg.min_dist) && (!any_hit || (t < best_t));

  assign cprev = cidx - 2'd1;
  assign csum = {prod_r[67], prod_r[67:16]} + {{21{corg[31]}}, corg};
  always_comb begin
    if (!csum[52] && (csum[51:31] != '0)) begin
      csat = 32'h7FFF_FFFF;
    end else if (csum[52] && (csum[51:31] != '1)) begin
      csat = 32'h8000_0000;
    end else begin
      csat = csum[31:0];
    end
  end

  assign res_we = out_pend && res_free;
  always_comb begin
    res.found = any_hit;
    res.distance = any_hit ? best_t : '0;
    res.index = any_hit ? best_index : '0;
    res.coord = any_hit ? coord : '0;
  end

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
    ctl_r <= uc;
    if (ctl_v) begin
      acc <= acc_next;
      if (ctl_r.last) begin
        case (ctl_r.dst)
          DST_P: begin
            p[ctl_r.dst_idx] <= acc_next[66:0];
          end
          DST_Q: begin
            q[ctl_r.dst_idx] <= acc_next[66:0];
          end
          DST_DET: begin
            det <= acc_next;
          end
          DST_UN: begin
            un <= acc_next;
          end
          DST_VN: begin
            vn <= acc_next;
          end
          DST_TN: begin
            tn <= acc_next;
          end
          default: begin
          end
        endcase
      end
    end
    if (item_take) begin
      cur <= item;
    end
    if (state == S_SIGN && det[AW-1]) begin
      det <= -det;
      un <= -un;
      vn <= -vn;
      tn <= -tn;
    end
    if (state == S_CHECK) begin
      hit_ok <= chk_ok;
      rem <= {tn[103:0], 16'b0};
      dsh <= {det, 30'b0};
      dbit <= 5'd30;
      t <= T_ALL_ONES;
    end
    if (state == S_DIV) begin
      if ({14'b0, rem} >= dsh) begin
        rem <= rem - dsh[119:0];
        t <= {t[29:0], 1'b1};
      end else begin
        t <= {t[29:0], 1'b0};
      end
      dsh <= dsh >> 1;
      dbit <= dbit - 5'd1;
    end
    if (state == S_COORD && cidx != 2'd0) begin
      coord[cprev] <= csat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_pend <= 1'b0;
      step <= '0;
      ctl_v <= 1'b0;
      cidx <= '0;
      best_t <= T_ALL_ONES;
      best_index <= '0;
      any_hit <= 1'b0;
      triangle_count <= '0;
    end else begin
      ctl_v <= (state == S_MUL);
      case (state)
        S_IDLE: begin
          if (item_take) begin
            step <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          step <= step + 6'd1;
          if (step == 6'(NUM_STEPS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_SIGN;
        end
        S_SIGN: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (chk_ok && !big) begin
            state <= S_DIV;
          end else begin
            state <= S_UPD;
          end
        end
        S_DIV: begin
          if (dbit == 5'd0) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (new_best) begin
            any_hit <= 1'b1;
            best_t <= t;
            best_index <= triangle_count;
          end
          if (triangle_count < INDEX_CAP) begin
            triangle_count <= triangle_count + 16'd1;
          end
          cidx <= '0;
          state <= cur.last ? S_COORD : S_IDLE;
        end
        S_COORD: begin
          cidx <= cidx + 2'd1;
          if (cidx == 2'd3) begin
            out_pend <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (res_we) begin
        out_pend <= 1'b0;
        best_t <= T_ALL_ONES;
        best_index <= '0;
        any_hit <= 1'b0;
        triangle_count <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> step <= 6'(NUM_STEPS - 1))
    else $error("product step out of range");
  a_div_only_hit: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> hit_ok)
    else $error("divider run for a rejected triangle");
  a_mesh_cleared: assert property (@(posedge clk) disable iff (rst)
    res_we |=> !any_hit && triangle_count == '0)
    else $error("mesh state not cleared after result");
  a_no_take_pending: assert property (@(posedge clk) disable iff (rst)
    out_pend |-> !item_take)
    else $error("item taken while result pending");
`endif

endmodule

### tb/ray_triangle_nearest_hit_top_tb.sv
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit_top_tb
// streams triangle meshes against programmed rays and checks every nearest-hit
// word against an exact fixed-point predictor, with random gaps on both sides
// ----------------------------------------------------------------------------
module ray_triangle_nearest_hit_top_tb import rtnh_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] v [9];
    logic        last;
  } tri_word_t;

  typedef struct {
    logic        found;
    logic [30:0] distance;
    logic [15:0] index;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } hit_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0;
  logic [31:0] c_x = '0, c_y = '0, c_z = '0;
  logic        last_triangle = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        found;
  logic [30:0] hit_distance;
  logic [15:0] hit_triangle;
  logic [31:0] hit_x, hit_y, hit_z;
  logic        wr_en = 1'b0;
  logic [2:0]  wr_index = '0;
  logic [62:0] wr_data = '0;

  ray_triangle_nearest_hit_top i_dut (.*);

  // ray registers and mesh state of the predictor
  logic signed [31:0] ray_org [3];
  logic signed [31:0] ray_dir [3];
  logic [62:0]        det_thr;
  logic [30:0]        min_dist;
  logic [30:0]        near_t;
  logic [15:0]        near_index;
  logic               near_valid;
  logic [15:0]        tri_count;

  hit_word_t hit_words_due [$];
  int        n_errors = 0;
  int        n_words = 0;
  int        n_found = 0;
  int        n_tris = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("ray_triangle_nearest_hit_top_tb NOT OK");
    $finish;
  end

  function automatic void clear_mesh();
    near_t = T_ALL_ONES;
    near_index = '0;
    near_valid = 1'b0;
    tri_count = '0;
  endfunction

  function automatic void reset_regs();
    foreach (ray_org[i]) ray_org[i] = '0;
    ray_dir[0] = '0;
    ray_dir[1] = '0;
    ray_dir[2] = 32'sd65536;
    det_thr = 63'd281474977;
    min_dist = '0;
    clear_mesh();
  endfunction

  function automatic logic signed [127:0] cross_part(logic signed [127:0] a1,
      logic signed [127:0] b2, logic signed [127:0] a2, logic signed [127:0] b1);
    return a1 * b2 - a2 * b1;
  endfunction

  function automatic logic [31:0] point_coord(logic signed [31:0] o,
      logic signed [31:0] d, logic [30:0] t);
    logic signed [127:0] p;
    logic signed [127:0] s;
    p = $signed({97'd0, t}) * 128'(d);
    s = (p >>> 16) + 128'(o);
    if (s > 128'sh7FFF_FFFF) s = 128'sh7FFF_FFFF;
    if (s < -128'sh8000_0000) s = -128'sh8000_0000;
    return s[31:0];
  endfunction

  // exact moller-trumbore test, accumulates the nearest hit of the mesh
  function automatic void nearest_hit_step(tri_word_t w);
    logic signed [127:0] e1 [3], e2 [3], tv [3], d [3], p [3], q [3];
    logic signed [127:0] det, un, vn, tn;
    logic [127:0] quo;
    logic [30:0] t;
    bit hit;
    hit_word_t r;
    for (int i = 0; i < 3; i++) begin
      e1[i] = 128'($signed(w.v[3+i])) - 128'($signed(w.v[i]));
      e2[i] = 128'($signed(w.v[6+i])) - 128'($signed(w.v[i]));
      tv[i] = 128'(ray_org[i]) - 128'($signed(w.v[i]));
      d[i] = 128'(ray_dir[i]);
    end
    p[0] = cross_part(d[1], e2[2], d[2], e2[1]);
    p[1] = cross_part(d[2], e2[0], d[0], e2[2]);
    p[2] = cross_part(d[0], e2[1], d[1], e2[0]);
    q[0] = cross_part(tv[1], e1[2], tv[2], e1[1]);
    q[1] = cross_part(tv[2], e1[0], tv[0], e1[2]);
    q[2] = cross_part(tv[0], e1[1], tv[1], e1[0]);
    det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
    un = tv[0] * p[0] + tv[1] * p[1] + tv[2] * p[2];
    vn = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    tn = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    hit = (det > $signed({65'd0, det_thr})) && un >= 0 && vn >= 0 && un + vn <= det
          && tn > 0;
    t = '0;
    if (hit) begin
      quo = (tn <<< 16) / det;
      t = (quo >= 128'h8000_0000) ? T_ALL_ONES : quo[30:0];
      if (t <= min_dist) hit = 0;
    end
    if (hit && (!near_valid || t < near_t)) begin
      near_valid = 1'b1;
      near_t = t;
      near_index = tri_count;
    end
    if (tri_count != INDEX_CAP) tri_count++;
    if (w.last) begin
      r = '{default: '0};
      if (near_valid) begin
        r.found = 1'b1;
        r.distance = near_t;
        r.index = near_index;
        r.x = point_coord(ray_org[0], ray_dir[0], near_t);
        r.y = point_coord(ray_org[1], ray_dir[1], near_t);
        r.z = point_coord(ray_org[2], ray_dir[2], near_t);
      end
      hit_words_due = {hit_words_due, r};
      clear_mesh();
    end
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [62:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_ORIGIN_X: ray_org[0] = val[31:0];
      REG_ORIGIN_Y: ray_org[1] = val[31:0];
      REG_ORIGIN_Z: ray_org[2] = val[31:0];
      REG_DIR_X:    ray_dir[0] = val[31:0];
      REG_DIR_Y:    ray_dir[1] = val[31:0];
      REG_DIR_Z:    ray_dir[2] = val[31:0];
      REG_DET_THR:  det_thr = val;
      default:      min_dist = val[30:0];
    endcase
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 9) < 6) ? 0 :
           ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 150);
  endfunction

  // sender: holds push across back-to-back words, lowers it only on a gap
  task automatic send_tri(tri_word_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk);
    end
    push <= 1'b1;
    {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} <=
        {w.v[0], w.v[1], w.v[2], w.v[3], w.v[4], w.v[5], w.v[6], w.v[7], w.v[8]};
    last_triangle <= w.last;
    do @(posedge clk); while (full);
    nearest_hit_step(w);
    n_tris++;
    @(negedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (hit_words_due.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic logic [31:0] q16(int whole);
    return 32'(whole) << 16;
  endfunction

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return q16($urandom_range(0, 20) - 10) + $urandom_range(0, 65535);
      default: return q16($urandom_range(0, 8) - 4);
    endcase
  endfunction

  // triangle around the ray origin in x and y, offset along z by a random distance
  function automatic tri_word_t aimed_tri(bit last);
    tri_word_t w;
    int dz;
    dz = $urandom_range(1, 30);
    for (int k = 0; k < 3; k++) begin
      w.v[3*k]   = ray_org[0] + q16($urandom_range(0, 6) - 3) + $urandom_range(0, 65535);
      w.v[3*k+1] = ray_org[1] + q16($urandom_range(0, 6) - 3) + $urandom_range(0, 65535);
      w.v[3*k+2] = ray_org[2] + q16(dz) + ($urandom_range(0, 3) == 0 ? $urandom() % 65536 : 0);
    end
    w.last = last;
    return w;
  endfunction

  initial begin
    tri_word_t w;
    tri_word_t dir_tab [$];
    hit_word_t fixed_tab [$];
    logic [31:0] ext [4];
    int mesh_len, mode;
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    reset_regs();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table: unit triangle hit, parallel, miss, behind, extremes
    w.v = '{q16(-1), q16(-1), q16(5), q16(3), q16(-1), q16(5), q16(-1), q16(3), q16(5)};
    w.last = 1; dir_tab = {dir_tab, w};
    fixed_tab = {fixed_tab, hit_word_t'{1, 31'(q16(5)), 0, 0, 0, q16(5)}};
    w.v = '{q16(0), q16(0), q16(1), q16(1), q16(0), q16(1), q16(0), q16(0), q16(2)};
    dir_tab = {dir_tab, w}; fixed_tab = {fixed_tab, hit_word_t'{0, 0, 0, 0, 0, 0}};
    w.v = '{q16(5), q16(5), q16(5), q16(6), q16(5), q16(5), q16(5), q16(6), q16(5)};
    dir_tab = {dir_tab, w}; fixed_tab = {fixed_tab, hit_word_t'{0, 0, 0, 0, 0, 0}};
    w.v = '{q16(-1), q16(-1), q16(-5), q16(3), q16(-1), q16(-5), q16(-1), q16(3), q16(-5)};
    dir_tab = {dir_tab, w}; fixed_tab = {fixed_tab, hit_word_t'{0, 0, 0, 0, 0, 0}};
    foreach (dir_tab[i]) begin
      send_tri(dir_tab[i]);
      hit_words_due[hit_words_due.size()-1] = fixed_tab[i];
    end
    for (int i = 0; i < 16; i++) begin
      foreach (w.v[j]) w.v[j] = ext[(i + j * (i / 4 + 1)) % 4];
      w.last = (i % 4 == 3);
      send_tri(w);
    end
    // two aimed triangles, a repeat of the second as a tie, and a far hit
    w = aimed_tri(0); send_tri(w);
    w = aimed_tri(0); send_tri(w);
    send_tri(w);
    w.v = '{q16(-1), q16(-1), 32'h7FFF_0000, q16(3), q16(-1), 32'h7FFF_0000,
            q16(-1), q16(3), 32'h7FFF_0000};
    w.last = 1; send_tri(w);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: ;
        1: begin
          write_reg(REG_ORIGIN_X, 63'(q16(2))); write_reg(REG_ORIGIN_Y, 63'(q16(-3)));
          write_reg(REG_ORIGIN_Z, 63'(q16(-1))); write_reg(REG_DIR_X, 63'd0);
          write_reg(REG_DIR_Y, 63'd0); write_reg(REG_DIR_Z, 63'(q16(1)));
          write_reg(REG_MIN_DIST, 63'(q16(3)));
        end
        2: begin
          write_reg(REG_DIR_X, 63'd0); write_reg(REG_DIR_Y, 63'd0);
          write_reg(REG_DIR_Z, 63'd0); write_reg(REG_MIN_DIST, 63'd0);
        end
        3: begin
          write_reg(REG_DIR_Z, 63'h7FFF_FFFF); write_reg(REG_DET_THR, '0);
          write_reg(REG_ORIGIN_X, 63'h7FFF_0000); write_reg(REG_ORIGIN_Z, 63'h8000_0000);
        end
        4: begin
          write_reg(REG_DIR_Z, 63'h8000_0000); write_reg(REG_DET_THR, '1);
        end
        5: begin
          write_reg(REG_DET_THR, 63'd281474977); write_reg(REG_DIR_Z, 63'(-q16(1)));
          write_reg(REG_DIR_X, 63'(q16(1) >> 2)); write_reg(REG_MIN_DIST, 63'h7FFF_FFFF);
        end
        default: begin
          for (int r = 0; r < 6; r++) write_reg(3'(r), 63'($urandom()) & 63'h0003_FFFF
                                                | (($urandom_range(0, 1)) ? '0 : '1) << 18);
          write_reg(REG_DIR_Z, 63'(q16(1) - $urandom_range(0, 3000)));
          write_reg(REG_DET_THR, 63'($urandom_range(0, 1000000)));
          write_reg(REG_MIN_DIST, 63'($urandom_range(0, 5) << 16));
        end
      endcase
      for (int m = 0; m < 56; m++) begin
        mesh_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 4);
        for (int k = 0; k < mesh_len; k++) begin
          mode = $urandom_range(0, 9);
          if (mode < 6) w = aimed_tri(k == mesh_len - 1);
          else begin
            foreach (w.v[j]) w.v[j] = rand_coord(mode % 3);
            w.last = (k == mesh_len - 1);
          end
          send_tri(w);
        end
      end
      drain();
    end

    $display("%0d triangles in %0d meshes, %0d words with a hit, %0d mismatches",
             n_tris, n_words, n_found, n_errors);
    $display("ray settings covered: defaults, offsets, zero and extreme directions, thresholds");
    if (n_errors == 0 && hit_words_due.size() == 0) begin
      $display("ray_triangle_nearest_hit_top_tb OK");
    end else begin
      $display("ray_triangle_nearest_hit_top_tb NOT OK");
    end
    $finish;
  end

  // receiver with random stalls
  initial begin
    int g;
    @(negedge clk);
    forever begin
      g = gap_len();
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(negedge clk);
      end
      pop <= 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    hit_word_t e;
    if (!rst && pop && !empty) begin
      n_words++;
      if (hit_words_due.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected hit word at %0t", $realtime);
      end else begin
        e = hit_words_due.pop_front();
        if (e.found) n_found++;
        if (found !== e.found || hit_distance !== e.distance || hit_triangle !== e.index ||
            hit_x !== e.x || hit_y !== e.y || hit_z !== e.z) begin
          n_errors++;
          if (n_errors <= 10)
            $display("word mismatch: exp %b %h %h %h %h %h got %b %h %h %h %h %h",
                     e.found, e.distance, e.index, e.x, e.y, e.z,
                     found, hit_distance, hit_triangle, hit_x, hit_y, hit_z);
        end
      end
    end
  end

endmodule
